### rtl/core/pnqt_pkg.sv
// Shared types and constants for the per-node quota trimmer.
// Used by pnqt_ctrl, pnqt_dp and per_node_quota_trimmer_top.
package pnqt_pkg;

  localparam int MAX_NODES  = 64;
  localparam int IDX_BITS   = $clog2(MAX_NODES);
  localparam int NL_BITS    = $clog2(MAX_NODES + 1);
  localparam int COUNT_BITS = 8;
  localparam int TOT_BITS   = 14;
  localparam int STS_BITS   = 2;

  typedef enum logic [STS_BITS-1:0] {
    ST_EQUAL   = 2'd0,
    ST_UNDER   = 2'd1,
    ST_TRIMMED = 2'd2,
    ST_FAIL    = 2'd3
  } pnqt_status_t;

  // controller -> datapath
  typedef struct packed {
    logic         load;        // input word accepted
    logic         start_run;   // latch node count, clear loader
    logic         set_status;
    pnqt_status_t status;
    logic         rank_hold;   // capture own count, clear sweep
    logic         sweep_rd;    // read compare node j
    logic         rank_wr;     // store rank and sorted count
    logic         pass_init;   // start a trimming pass
    logic         trim_rd;     // read sorted entry p
    logic         out_fetch2;  // read sorted entry at node rank
    logic         out_load;    // fill output register
    logic         out_next;
  } pnqt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic same;
    logic under;
    logic excess_zero;
    logic sweep_last;
    logic idx_last;
    logic pass_last;
    logic no_progress;
    logic out_taken;
  } pnqt_sts_t;

endpackage

### rtl/core/per_node_quota_trimmer_top.sv
// Top level of the per-node quota trimmer.
// Usage:
//   Input: one word per node (in_node_count, in_last_node), index order, on
//   in_valid/in_stall; one word per cycle while loading. Words beyond 64
//   nodes are dropped except that their last mark still ends the run.
//   Config: cfg_max_total on cfg_valid/cfg_ready, always ready; write only
//   while idle.
//   Output: after the last word, one word per node in index order with
//   node index, new count, status and a last mark, on out_valid/out_stall.
// Flow (n nodes):
//   The decision state follows the last word. Equal or under-limit runs go
//   straight to output. Otherwise ranking scans the count memory once per
//   node. Each trimming pass reads min(n, excess) sorted entries;
//   the pass count is set by the excess and the counts.
//   Each result passes through the memory read chain and waits out any
//   stall; in_stall stays high from the last word until the final
//   result is taken. A stalled output word holds until taken.
// Reset: rst_n synchronous active low; clears max_total, loader state and
//   control; memory contents are undefined until written.
// Depends on pnqt_pkg, pnqt_ctrl and pnqt_dp.
module per_node_quota_trimmer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [pnqt_pkg::COUNT_BITS-1:0]      in_node_count,
  input  logic                                 in_last_node,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pnqt_pkg::TOT_BITS-1:0]        cfg_max_total,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pnqt_pkg::IDX_BITS-1:0]        out_node_index,
  output logic [pnqt_pkg::COUNT_BITS-1:0]      out_new_count,
  output logic [pnqt_pkg::STS_BITS-1:0]        out_status,
  output logic                                 out_last_result
);
  import pnqt_pkg::*;

  pnqt_cmd_t cmd;
  pnqt_sts_t sts;

  assign cfg_ready = 1'b1;

  pnqt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_node (in_last_node),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  pnqt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_node_count   (in_node_count),
    .cfg_valid       (cfg_valid),
    .cfg_max_total   (cfg_max_total),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_node_index  (out_node_index),
    .out_new_count   (out_new_count),
    .out_status      (out_status),
    .out_last_result (out_last_result)
  );

endmodule

### rtl/core/pnqt_ctrl.sv
// Sequencer for the per-node quota trimmer: load, decide, rank, trim, emit.
// Depends on pnqt_pkg for command and status structs.
module pnqt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last_node,
  output logic               in_stall,
  input  pnqt_pkg::pnqt_sts_t sts,
  output pnqt_pkg::pnqt_cmd_t cmd
);
  import pnqt_pkg::*;

  typedef enum logic [14:0] {
    S_LOAD       = 15'h0001,
    S_DECIDE     = 15'h0002,
    S_RANK_LD    = 15'h0004,
    S_RANK_HOLD  = 15'h0008,
    S_SWEEP      = 15'h0010,
    S_RANK_END   = 15'h0020,
    S_RANK_WR    = 15'h0040,
    S_TRIM_START = 15'h0080,
    S_TRIM_RUN   = 15'h0100,
    S_TRIM_DRAIN = 15'h0200,
    S_TRIM_CHECK = 15'h0400,
    S_OUT_RD     = 15'h0800,
    S_OUT_RD2    = 15'h1000,
    S_OUT_LD     = 15'h2000,
    S_OUT_WAIT   = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_LOAD);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = ST_EQUAL;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last_node) state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.start_run = 1'b1;
        if (sts.same) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_EQUAL;
          state_nxt      = S_OUT_RD;
        end else if (sts.under) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_UNDER;
          state_nxt      = S_OUT_RD;
        end else begin
          state_nxt = S_RANK_LD;
        end
      end
      S_RANK_LD:   state_nxt = S_RANK_HOLD;
      S_RANK_HOLD: begin
        cmd.rank_hold = 1'b1;
        state_nxt     = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        if (sts.sweep_last) state_nxt = S_RANK_END;
      end
      S_RANK_END:  state_nxt = S_RANK_WR;
      S_RANK_WR: begin
        cmd.rank_wr = 1'b1;
        state_nxt   = sts.idx_last ? S_TRIM_START : S_RANK_LD;
      end
      S_TRIM_START: begin
        if (sts.excess_zero) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_TRIMMED;
          state_nxt      = S_OUT_RD;
        end else begin
          cmd.pass_init = 1'b1;
          state_nxt     = S_TRIM_RUN;
        end
      end
      S_TRIM_RUN: begin
        cmd.trim_rd = 1'b1;
        if (sts.pass_last) state_nxt = S_TRIM_DRAIN;
      end
      S_TRIM_DRAIN: state_nxt = S_TRIM_CHECK;
      S_TRIM_CHECK: begin
        if (sts.no_progress) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FAIL;
          state_nxt      = S_OUT_RD;
        end else begin
          state_nxt = S_TRIM_START;
        end
      end
      S_OUT_RD:  state_nxt = S_OUT_RD2;
      S_OUT_RD2: begin
        cmd.out_fetch2 = 1'b1;
        state_nxt      = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (sts.out_taken) begin
          cmd.out_next = 1'b1;
          state_nxt    = sts.idx_last ? S_LOAD : S_OUT_RD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_LOAD;
    else        state_r <= state_nxt;
  end

  // input is only taken while loading
  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_LOAD)
    else $error("load outside load state");
  // a run always goes through the decision step right after its last word
  a_last_decides: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_node) |=> state_r == S_DECIDE)
    else $error("last word did not start a decision");
  // setting the status leads straight into output; it is fixed once per run
  a_status_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_status |=> state_r == S_OUT_RD)
    else $error("status set without entering output");

endmodule

### rtl/core/pnqt_dp.sv
// Datapath for the per-node quota trimmer: count, rank and sorted-count
// memories, loader totals, trim pass counters and output register.
// Depends on pnqt_pkg for constants and structs.
module pnqt_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pnqt_pkg::pnqt_cmd_t                  cmd,
  output pnqt_pkg::pnqt_sts_t                  sts,
  input  logic [pnqt_pkg::COUNT_BITS-1:0]      in_node_count,
  input  logic                                 cfg_valid,
  input  logic [pnqt_pkg::TOT_BITS-1:0]        cfg_max_total,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [pnqt_pkg::IDX_BITS-1:0]        out_node_index,
  output logic [pnqt_pkg::COUNT_BITS-1:0]      out_new_count,
  output logic [pnqt_pkg::STS_BITS-1:0]        out_status,
  output logic                                 out_last_result
);
  import pnqt_pkg::*;

  logic [COUNT_BITS-1:0] node_mem [MAX_NODES];
  logic [COUNT_BITS-1:0] trim_mem [MAX_NODES];
  logic [IDX_BITS-1:0]   rank_mem [MAX_NODES];

  logic [TOT_BITS-1:0]   max_r;
  logic [NL_BITS-1:0]    nl_r;
  logic [NL_BITS-1:0]    n_r;
  logic [TOT_BITS-1:0]   total_r;
  logic [COUNT_BITS-1:0] first_r;
  logic                  same_r;

  logic [IDX_BITS-1:0]   idx_r;
  logic [IDX_BITS-1:0]   j_r;
  logic [IDX_BITS-1:0]   cmp_j_r;
  logic                  cmp_pend_r;
  logic [COUNT_BITS-1:0] cnt_i_r;
  logic [IDX_BITS-1:0]   acc_r;

  logic [COUNT_BITS-1:0] rd_a_r;
  logic [COUNT_BITS-1:0] rd_b_r;
  logic [IDX_BITS-1:0]   rank_rd_r;
  logic [COUNT_BITS-1:0] trim_rd_r;

  logic [TOT_BITS-1:0]   excess_r;
  logic [TOT_BITS-1:0]   old_r;
  logic [NL_BITS-1:0]    lim_r;
  logic [IDX_BITS-1:0]   p_r;
  logic [IDX_BITS-1:0]   wb_addr_r;
  logic                  wb_pend_r;
  pnqt_status_t          status_r;

  logic                  out_valid_r;
  logic [IDX_BITS-1:0]   out_idx_r;
  logic [COUNT_BITS-1:0] out_cnt_r;
  logic [STS_BITS-1:0]   out_sts_r;
  logic                  out_last_r;

  logic                  load_ok;
  logic                  hit;
  logic                  wb_dec;
  logic [IDX_BITS-1:0]   n_last;
  logic [NL_BITS-1:0]    lim_nxt;

  assign load_ok = cmd.load && (nl_r < NL_BITS'(MAX_NODES));
  assign n_last  = IDX_BITS'(n_r - NL_BITS'(1));
  // node j stands before node i: larger count, or equal count and larger index
  assign hit     = (rd_b_r > cnt_i_r) || ((rd_b_r == cnt_i_r) && (cmp_j_r > idx_r));
  assign wb_dec  = wb_pend_r && (trim_rd_r > COUNT_BITS'(1));
  assign lim_nxt = (excess_r >= TOT_BITS'(n_r)) ? n_r : NL_BITS'(excess_r);

  assign sts.same        = same_r;
  assign sts.under       = (total_r <= max_r);
  assign sts.excess_zero = (excess_r == '0);
  assign sts.sweep_last  = (j_r == n_last);
  assign sts.idx_last    = (idx_r == n_last);
  assign sts.pass_last   = ({1'b0, p_r} == lim_r - NL_BITS'(1));
  assign sts.no_progress = (excess_r == old_r);
  assign sts.out_taken   = out_valid_r && !out_stall;

  // memories
  always_ff @(posedge clk) begin
    if (load_ok) node_mem[nl_r[IDX_BITS-1:0]] <= in_node_count;
    rd_a_r <= node_mem[idx_r];
    rd_b_r <= node_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.rank_wr) rank_mem[idx_r] <= acc_r;
    rank_rd_r <= rank_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.rank_wr)  trim_mem[acc_r] <= cnt_i_r;
    else if (wb_dec)  trim_mem[wb_addr_r] <= trim_rd_r - COUNT_BITS'(1);
    if (cmd.trim_rd)         trim_rd_r <= trim_mem[p_r];
    else if (cmd.out_fetch2) trim_rd_r <= trim_mem[rank_rd_r];
  end

  // config, loader and control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r      <= '0;
      nl_r       <= '0;
      n_r        <= '0;
      total_r    <= '0;
      same_r     <= 1'b1;
      idx_r      <= '0;
      j_r        <= '0;
      cmp_pend_r <= 1'b0;
      acc_r      <= '0;
      excess_r   <= '0;
      old_r      <= '0;
      lim_r      <= '0;
      p_r        <= '0;
      wb_pend_r  <= 1'b0;
      status_r   <= ST_EQUAL;
    end else begin
      if (cfg_valid) max_r <= cfg_max_total;

      if (load_ok) begin
        nl_r    <= nl_r + NL_BITS'(1);
        total_r <= total_r + TOT_BITS'(in_node_count);
        if (nl_r == '0) begin
          same_r <= 1'b1;
        end else if (in_node_count != first_r) begin
          same_r <= 1'b0;
        end
      end

      if (cmd.start_run) begin
        n_r      <= nl_r;
        nl_r     <= '0;
        total_r  <= '0;
        idx_r    <= '0;
        excess_r <= total_r - max_r;
      end

      if (cmd.set_status) status_r <= cmd.status;

      if (cmd.rank_hold) begin
        j_r   <= '0;
        acc_r <= '0;
      end else begin
        if (cmd.sweep_rd) j_r <= j_r + IDX_BITS'(1);
        if (cmp_pend_r && hit) acc_r <= acc_r + IDX_BITS'(1);
      end
      cmp_pend_r <= cmd.sweep_rd;

      if (cmd.rank_wr || cmd.out_next) begin
        idx_r <= sts.idx_last ? '0 : idx_r + IDX_BITS'(1);
      end

      if (cmd.pass_init) begin
        old_r <= excess_r;
        lim_r <= lim_nxt;
        p_r   <= '0;
      end else if (cmd.trim_rd) begin
        p_r <= p_r + IDX_BITS'(1);
      end
      wb_pend_r <= cmd.trim_rd;
      if (wb_dec) excess_r <= excess_r - TOT_BITS'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load_ok && nl_r == '0) first_r <= in_node_count;
    if (cmd.rank_hold) cnt_i_r <= rd_a_r;
    if (cmd.rank_hold) cmp_j_r <= '0;
    else               cmp_j_r <= j_r;
    if (cmd.trim_rd)   wb_addr_r <= p_r;
    if (cmd.out_load) begin
      out_idx_r  <= idx_r;
      out_cnt_r  <= (status_r == ST_TRIMMED) ? trim_rd_r : rd_a_r;
      out_sts_r  <= status_r;
      out_last_r <= sts.idx_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)              out_valid_r <= 1'b0;
    else if (cmd.out_load)   out_valid_r <= 1'b1;
    else if (sts.out_taken)  out_valid_r <= 1'b0;
  end

  assign out_valid       = out_valid_r;
  assign out_node_index  = out_idx_r;
  assign out_new_count   = out_cnt_r;
  assign out_status      = out_sts_r;
  assign out_last_result = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r)
    else $error("output register overwritten while full");
  a_wb_vs_rank: assert property (@(posedge clk) disable iff (!rst_n)
    wb_pend_r |-> !cmd.rank_wr)
    else $error("trim write-back collides with rank write");
  a_excess_down: assert property (@(posedge clk) disable iff (!rst_n)
    wb_pend_r |=> excess_r <= $past(excess_r))
    else $error("excess grew during a pass");
  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_run |=> (nl_r == '0) && (total_r == '0))
    else $error("loader not cleared at run start");

endmodule
